@@ rtl/nine_slice_quad_generator_unit_defines.svh @@
// Assertion macros for the nine-slice quad generator.
// Used by nsq_pipe and nsq_emit; expects i_clk and i_rst_n in scope.
`ifndef NINE_SLICE_QUAD_GENERATOR_UNIT_DEFINES_SVH
`define NINE_SLICE_QUAD_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define NSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);
`else
`define NSQ_ASSERT(lbl, prop, msg)
`define NSQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/nsq_pkg.sv @@
// Shared types, constants and saturation helpers for the nine-slice quad generator.
// No dependencies.
package nsq_pkg;

    localparam int SLICE_MAX  = 32112;
    localparam int CORNER_MAX = 2048;
    localparam int DIV_QB     = 16;   // quotient bits
    localparam int DIV_DW     = 13;   // divisor width
    localparam int DIV_NW     = 31;   // dividend width
    localparam int X_W        = 18;   // signed screen boundary width
    localparam int U_W        = 20;   // signed texture boundary width

    typedef enum logic [3:0] {
        REG_TEX_LEFT       = 4'd0,
        REG_TEX_TOP        = 4'd1,
        REG_TEX_RIGHT      = 4'd2,
        REG_TEX_BOTTOM     = 4'd3,
        REG_SOURCE_WIDTH   = 4'd4,
        REG_SOURCE_HEIGHT  = 4'd5,
        REG_SLICE_FRACTION = 4'd6,
        REG_DRAWN_CORNER   = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [16:0] tl;
        logic [16:0] tt;
        logic [16:0] tr;
        logic [16:0] tb;
        logic [14:0] sl;     // clamped slice fraction
        logic [11:0] cn;     // clamped drawn corner
        logic [27:0] slsw;   // sl * source_width
        logic [27:0] slmn;   // sl * min(source_width, source_height)
        logic [12:0] dsw;    // max(1, source_width)
        logic [12:0] dsh;    // max(1, source_height)
    } t_cfg;

    typedef struct packed {
        logic               strip;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [15:0]        cs;
        logic [31:0]        tint;
    } t_req;

    typedef struct packed {
        logic [3:0][X_W-1:0] xs;
        logic [3:0][X_W-1:0] ys;
        logic [3:0][U_W-1:0] us;
        logic [3:0][U_W-1:0] vs;
        logic [31:0]         tint;
        logic [8:0]          mask;
    } t_geom;

    function automatic logic [15:0] sat_coord(input logic signed [X_W-1:0] v);
        logic [15:0] r;
        if (v > 18'sd32767)       r = 16'h7fff;
        else if (v < -18'sd32768) r = 16'h8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic [14:0] sat_len(input logic signed [X_W-1:0] v);
        logic [14:0] r;
        if (v < 18'sd0)           r = '0;
        else if (v > 18'sd32767)  r = 15'h7fff;
        else                      r = v[14:0];
        return r;
    endfunction

    function automatic logic [16:0] sat_uv(input logic signed [U_W-1:0] v);
        logic [16:0] r;
        if (v < 20'sd0)           r = '0;
        else if (v > 20'sd65536)  r = 17'h10000;
        else                      r = v[16:0];
        return r;
    endfunction

    // lowest set cell, row-major
    function automatic logic [3:0] first_cell(input logic [8:0] m);
        logic [3:0] k;
        k = 4'd0;
        for (int i = 8; i >= 0; i--) begin
            if (m[i]) k = 4'(i);
        end
        return k;
    endfunction

    function automatic logic [1:0] cell_col(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] cell_row(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/nine_slice_quad_generator_unit.sv @@
// channel | direction | handshake           | word
// request | in        | i_in_valid/o_in_stall | strip, pos, span, corner scale, tint
// quad    | out       | o_out_valid/i_out_stall | quad rect, uv rect, tint, last flag
// config  | in        | i_cfg_valid/o_cfg_ready | register index, data
// A request enters every cycle unless o_in_stall is high; a 21-stage geometry
// pipeline (three restoring dividers) feeds the emitter, which sends one quad
// per cycle while i_out_stall is low, one for each non-empty cell of a request;
// a request with no quads does not occupy it. Reset clears the valid bits
// and loads the register defaults. Output stall freezes the emitter and then
// the whole pipeline; nothing is dropped or repeated.
module nine_slice_quad_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_strip_layout,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_span_w,
    input  logic signed [15:0] i_span_h,
    input  logic [15:0] i_corner_scale,
    input  logic [31:0] i_tint_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_quad_x,
    output logic signed [15:0] o_quad_y,
    output logic [14:0] o_quad_w,
    output logic [14:0] o_quad_h,
    output logic [16:0] o_quad_u0,
    output logic [16:0] o_quad_v0,
    output logic [16:0] o_quad_u1,
    output logic [16:0] o_quad_v1,
    output logic [31:0] o_tint_out,
    output logic        o_last_quad,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    logic [16:0] r_tex_left, r_tex_top, r_tex_right, r_tex_bottom;
    logic [12:0] r_source_width, r_source_height;
    logic [14:0] r_slice_fraction;
    logic [11:0] r_drawn_corner;
    logic [27:0] r_slsw, r_slmn;
    logic [14:0] sl;
    logic [11:0] cn;
    logic [12:0] mn;
    nsq_pkg::t_cfg  cfg;
    nsq_pkg::t_req  req;
    nsq_pkg::t_geom geom;
    logic pv, take;
    logic [15:0] qx, qy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_left       <= 17'd0;
            r_tex_top        <= 17'd0;
            r_tex_right      <= 17'd65536;
            r_tex_bottom     <= 17'd65536;
            r_source_width   <= 13'd16;
            r_source_height  <= 13'd16;
            r_slice_fraction <= 15'd0;
            r_drawn_corner   <= 12'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                nsq_pkg::REG_TEX_LEFT:       r_tex_left       <= i_cfg_data;
                nsq_pkg::REG_TEX_TOP:        r_tex_top        <= i_cfg_data;
                nsq_pkg::REG_TEX_RIGHT:      r_tex_right      <= i_cfg_data;
                nsq_pkg::REG_TEX_BOTTOM:     r_tex_bottom     <= i_cfg_data;
                nsq_pkg::REG_SOURCE_WIDTH:   r_source_width   <= i_cfg_data[12:0];
                nsq_pkg::REG_SOURCE_HEIGHT:  r_source_height  <= i_cfg_data[12:0];
                nsq_pkg::REG_SLICE_FRACTION: r_slice_fraction <= i_cfg_data[14:0];
                nsq_pkg::REG_DRAWN_CORNER:   r_drawn_corner   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign sl = (r_slice_fraction > 15'(nsq_pkg::SLICE_MAX)) ? 15'(nsq_pkg::SLICE_MAX)
                                                               : r_slice_fraction;
    assign cn = (r_drawn_corner > 12'(nsq_pkg::CORNER_MAX)) ? 12'(nsq_pkg::CORNER_MAX)
                                                             : r_drawn_corner;
    assign mn = (r_source_width < r_source_height) ? r_source_width : r_source_height;

    // config products, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_slsw <= {13'd0, sl} * {15'd0, r_source_width};
        r_slmn <= {13'd0, sl} * {15'd0, mn};
    end

    always_comb begin
        cfg.tl   = r_tex_left;
        cfg.tt   = r_tex_top;
        cfg.tr   = r_tex_right;
        cfg.tb   = r_tex_bottom;
        cfg.sl   = sl;
        cfg.cn   = cn;
        cfg.slsw = r_slsw;
        cfg.slmn = r_slmn;
        cfg.dsw  = (r_source_width == '0) ? 13'd1 : r_source_width;
        cfg.dsh  = (r_source_height == '0) ? 13'd1 : r_source_height;
        req.strip = i_strip_layout;
        req.x     = i_pos_x;
        req.y     = i_pos_y;
        req.w     = i_span_w;
        req.h     = i_span_h;
        req.cs    = i_corner_scale;
        req.tint  = i_tint_in;
    end

    nsq_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (req),
        .i_cfg   (cfg),
        .o_valid (pv),
        .i_take  (take),
        .o_geom  (geom)
    );

    nsq_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (pv),
        .i_geom      (geom),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_quad_x    (qx),
        .o_quad_y    (qy),
        .o_quad_w    (o_quad_w),
        .o_quad_h    (o_quad_h),
        .o_quad_u0   (o_quad_u0),
        .o_quad_v0   (o_quad_v0),
        .o_quad_u1   (o_quad_u1),
        .o_quad_v1   (o_quad_v1),
        .o_tint_out  (o_tint_out),
        .o_last_quad (o_last_quad)
    );

    assign o_quad_x = $signed(qx);
    assign o_quad_y = $signed(qy);

endmodule

@@ rtl/nsq_pipe.sv @@
// Geometry pipeline: products, three pipelined dividers, cell boundaries and mask.
// Depends on nsq_pkg and the defines header.
`include "nine_slice_quad_generator_unit_defines.svh"
module nsq_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  nsq_pkg::t_req  i_item,
    input  nsq_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    input  logic           i_take,
    output nsq_pkg::t_geom o_geom
);

    localparam int NQ = nsq_pkg::DIV_QB;

    typedef struct packed {
        logic               strip;
        logic               plain;
        logic               reject;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [31:0]        tint;
        logic               dxn;
        logic               dyn;
        logic [15:0]        inset;
        logic [15:0]        c9;
    } t_side;

    logic en;
    assign en      = !o_valid || i_take;
    assign o_stall = !en;

    // stage 1
    logic        r_v1;
    t_side       r_side1, n_side1;
    logic [30:0] r_hcs;
    logic [16:0] r_adx, r_ady;
    logic [17:0] dx, dy;
    logic [16:0] adx, ady;
    logic [31:0] sins;
    logic [27:0] c9p;

    always_comb begin
        dx   = {1'b0, i_cfg.tr} - {1'b0, i_cfg.tl};
        dy   = {1'b0, i_cfg.tb} - {1'b0, i_cfg.tt};
        adx  = dx[17] ? 17'(18'd0 - dx) : dx[16:0];
        ady  = dy[17] ? 17'(18'd0 - dy) : dy[16:0];
        sins = {15'd0, adx} * {17'd0, i_cfg.sl};
        c9p  = {16'd0, i_cfg.cn} * {12'd0, i_item.cs};
        n_side1.strip  = i_item.strip;
        n_side1.plain  = (i_cfg.sl == '0);
        n_side1.reject = i_item.w[15] || (i_item.w == '0) || i_item.h[15] || (i_item.h == '0);
        n_side1.x      = i_item.x;
        n_side1.y      = i_item.y;
        n_side1.w      = i_item.w[14:0];
        n_side1.h      = i_item.h[14:0];
        n_side1.tint   = i_item.tint;
        n_side1.dxn    = dx[17];
        n_side1.dyn    = dy[17];
        n_side1.inset  = sins[31:16];
        n_side1.c9     = c9p[27:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side1 <= n_side1;
            r_hcs   <= {16'd0, i_item.h[14:0]} * {15'd0, i_item.cs};
            r_adx   <= adx;
            r_ady   <= ady;
        end
    end

    // stage 2: wide products, corner clamp
    logic        r_v2;
    t_side       r_side2, n_side2;
    logic [nsq_pkg::DIV_NW-1:0] r_num2 [0:2];
    logic [58:0] pcap;
    logic [44:0] piu, piv;
    logic [13:0] half9;

    always_comb begin
        pcap  = {28'd0, r_hcs} * {31'd0, i_cfg.slsw};
        piu   = {28'd0, r_adx} * {17'd0, i_cfg.slmn};
        piv   = {28'd0, r_ady} * {17'd0, i_cfg.slmn};
        half9 = (r_side1.w < r_side1.h) ? r_side1.w[14:1] : r_side1.h[14:1];
        n_side2 = r_side1;
        if (r_side1.c9 > {2'b0, half9}) n_side2.c9 = {2'b0, half9};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side2   <= n_side2;
            r_num2[0] <= pcap[58:28];
            r_num2[1] <= {2'b0, piu[44:16]};
            r_num2[2] <= {2'b0, piv[44:16]};
        end
    end

    // divider section: index 0 is the setup stage, then one quotient bit per stage
    logic [12:0] dl [0:2];
    assign dl[0] = i_cfg.dsh;
    assign dl[1] = i_cfg.dsw;
    assign dl[2] = i_cfg.dsh;

    logic [NQ:0] r_dv;
    t_side       r_dside [0:NQ];
    logic [12:0] r_drem  [0:NQ][0:2];
    logic [NQ-1:0] r_dlow [0:NQ][0:2];
    logic [NQ-1:0] r_dq   [0:NQ][0:2];
    logic        r_dovf  [0:NQ][0:2];
    logic [12:0] n_drem  [1:NQ][0:2];
    logic [NQ-1:0] n_dq   [1:NQ][0:2];
    logic [14:0] top0    [0:2];

    always_comb begin
        logic [13:0] rem2;
        logic        ge;
        for (int l = 0; l < 3; l++) begin
            top0[l] = r_num2[l][nsq_pkg::DIV_NW-1:NQ];
        end
        for (int k = 1; k <= NQ; k++) begin
            for (int l = 0; l < 3; l++) begin
                rem2 = {r_drem[k-1][l], r_dlow[k-1][l][NQ-1]};
                ge   = (rem2 >= {1'b0, dl[l]});
                n_drem[k][l] = ge ? 13'(rem2 - {1'b0, dl[l]}) : rem2[12:0];
                n_dq[k][l]   = {r_dq[k-1][l][NQ-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (en) begin
            r_dv <= {r_dv[NQ-1:0], r_v2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dside[0] <= r_side2;
            for (int l = 0; l < 3; l++) begin
                r_dovf[0][l] <= (top0[l] >= {2'b0, dl[l]});
                r_drem[0][l] <= top0[l][12:0];
                r_dlow[0][l] <= r_num2[l][NQ-1:0];
                r_dq[0][l]   <= '0;
            end
            for (int k = 1; k <= NQ; k++) begin
                r_dside[k] <= r_dside[k-1];
                for (int l = 0; l < 3; l++) begin
                    r_dovf[k][l] <= r_dovf[k-1][l];
                    r_drem[k][l] <= n_drem[k][l];
                    r_dlow[k][l] <= {r_dlow[k-1][l][NQ-2:0], 1'b0};
                    r_dq[k][l]   <= n_dq[k][l];
                end
            end
        end
    end

    // F1: pick corner sizes and texture insets per layout
    logic        r_vf1;
    t_side       r_sidef1;
    logic [13:0] r_cx, r_cy, n_cx, n_cy;
    logic [17:0] r_iu, r_iv, n_iu, n_iv;
    logic [13:0] halfw, capc;
    logic [15:0] qc;

    always_comb begin
        qc    = r_dq[NQ][0];
        halfw = r_dside[NQ].w[14:1];
        capc  = (r_dovf[NQ][0] || (qc > {2'b0, halfw})) ? halfw : qc[13:0];
        n_cx = '0;
        n_cy = '0;
        n_iu = '0;
        n_iv = '0;
        if (r_dside[NQ].plain) begin
            n_cx = '0;
        end else if (r_dside[NQ].strip) begin
            n_cx = capc;
            n_iu = r_dside[NQ].dxn ? 18'(18'd0 - {2'b0, r_dside[NQ].inset})
                                   : {2'b0, r_dside[NQ].inset};
        end else begin
            n_cx = r_dside[NQ].c9[13:0];
            n_cy = r_dside[NQ].c9[13:0];
            n_iu = r_dside[NQ].dxn ? 18'(18'd0 - {2'b0, r_dq[NQ][1]}) : {2'b0, r_dq[NQ][1]};
            n_iv = r_dside[NQ].dyn ? 18'(18'd0 - {2'b0, r_dq[NQ][2]}) : {2'b0, r_dq[NQ][2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf1 <= 1'b0;
        end else if (en) begin
            r_vf1 <= r_dv[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sidef1 <= r_dside[NQ];
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_iu <= n_iu;
            r_iv <= n_iv;
        end
    end

    // F2: boundaries and non-empty cell mask
    logic r_vf2;
    nsq_pkg::t_geom r_geom, n_geom;

    always_comb begin
        logic [17:0] x0, y0, wx, hy, cx, cy;
        logic [19:0] iu, iv;
        x0 = {{2{r_sidef1.x[15]}}, r_sidef1.x};
        y0 = {{2{r_sidef1.y[15]}}, r_sidef1.y};
        wx = {3'b0, r_sidef1.w};
        hy = {3'b0, r_sidef1.h};
        cx = {4'b0, r_cx};
        cy = {4'b0, r_cy};
        iu = {{2{r_iu[17]}}, r_iu};
        iv = {{2{r_iv[17]}}, r_iv};
        n_geom.xs[0] = x0;
        n_geom.xs[1] = x0 + cx;
        n_geom.xs[2] = x0 + wx - cx;
        n_geom.xs[3] = x0 + wx;
        n_geom.ys[0] = y0;
        n_geom.ys[1] = y0 + cy;
        n_geom.ys[2] = y0 + hy - cy;
        n_geom.ys[3] = y0 + hy;
        n_geom.us[0] = {3'b0, i_cfg.tl};
        n_geom.us[1] = {3'b0, i_cfg.tl} + iu;
        n_geom.us[2] = {3'b0, i_cfg.tr} - iu;
        n_geom.us[3] = {3'b0, i_cfg.tr};
        n_geom.vs[0] = {3'b0, i_cfg.tt};
        n_geom.vs[1] = {3'b0, i_cfg.tt} + iv;
        n_geom.vs[2] = {3'b0, i_cfg.tb} - iv;
        n_geom.vs[3] = {3'b0, i_cfg.tb};
        n_geom.tint  = r_sidef1.tint;
        for (int r = 0; r < 3; r++) begin
            for (int q = 0; q < 3; q++) begin
                n_geom.mask[r*3+q] = !r_sidef1.reject
                    && ($signed(n_geom.xs[q+1]) > $signed(n_geom.xs[q]))
                    && ($signed(n_geom.ys[r+1]) > $signed(n_geom.ys[r]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf2 <= 1'b0;
        end else if (en) begin
            r_vf2 <= r_vf1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geom <= n_geom;
        end
    end

    assign o_valid = r_vf2;
    assign o_geom  = r_geom;

    `NSQ_ASSERT_NEXT(a_hold_out, o_valid && !i_take, o_valid && $stable(o_geom), "pipe output lost under stall")
    `NSQ_ASSERT_NEXT(a_div_moves, en && r_dv[NQ], r_vf1, "divider result dropped")
    `NSQ_ASSERT(a_stall_full, o_stall |-> o_valid, "input stalled with empty output stage")

endmodule

@@ rtl/nsq_emit.sv @@
// Quad emitter: walks the non-empty cells of one item into the output register, one quad per cycle when not stalled.
// Depends on nsq_pkg and the defines header.
`include "nine_slice_quad_generator_unit_defines.svh"
module nsq_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  nsq_pkg::t_geom i_geom,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [15:0]    o_quad_x,
    output logic [15:0]    o_quad_y,
    output logic [14:0]    o_quad_w,
    output logic [14:0]    o_quad_h,
    output logic [16:0]    o_quad_u0,
    output logic [16:0]    o_quad_v0,
    output logic [16:0]    o_quad_u1,
    output logic [16:0]    o_quad_v1,
    output logic [31:0]    o_tint_out,
    output logic           o_last_quad
);

    nsq_pkg::t_geom r_item;
    logic [8:0]     r_mask, n_mask;
    logic           r_ov, n_ov;
    logic           out_free, emit, take;
    logic [3:0]     k;
    logic [1:0]     qc, rc;
    logic [15:0]    r_x, r_y;
    logic [14:0]    r_w, r_h;
    logic [16:0]    r_u0, r_v0, r_u1, r_v1;
    logic [31:0]    r_tint;
    logic           r_last;

    assign out_free = !r_ov || !i_out_stall;
    assign emit     = (r_mask != '0) && out_free;
    assign take     = i_valid && ((i_geom.mask == '0) || (r_mask == '0)
                                  || (out_free && $onehot(r_mask)));
    assign o_take   = take;

    assign k  = nsq_pkg::first_cell(r_mask);
    assign qc = nsq_pkg::cell_col(k);
    assign rc = nsq_pkg::cell_row(k);

    always_comb begin
        n_mask = r_mask;
        if (emit) n_mask = r_mask & (r_mask - 9'd1);
        if (take && (i_geom.mask != '0)) n_mask = i_geom.mask;
        n_ov = r_ov;
        if (emit)          n_ov = 1'b1;
        else if (out_free) n_ov = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_mask <= n_mask;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && (i_geom.mask != '0)) begin
            r_item <= i_geom;
        end
        if (emit) begin
            r_x    <= nsq_pkg::sat_coord($signed(r_item.xs[qc]));
            r_y    <= nsq_pkg::sat_coord($signed(r_item.ys[rc]));
            r_w    <= nsq_pkg::sat_len($signed(r_item.xs[qc + 2'd1]) - $signed(r_item.xs[qc]));
            r_h    <= nsq_pkg::sat_len($signed(r_item.ys[rc + 2'd1]) - $signed(r_item.ys[rc]));
            r_u0   <= nsq_pkg::sat_uv($signed(r_item.us[qc]));
            r_u1   <= nsq_pkg::sat_uv($signed(r_item.us[qc + 2'd1]));
            r_v0   <= nsq_pkg::sat_uv($signed(r_item.vs[rc]));
            r_v1   <= nsq_pkg::sat_uv($signed(r_item.vs[rc + 2'd1]));
            r_tint <= r_item.tint;
            r_last <= $onehot(r_mask);
        end
    end

    assign o_out_valid = r_ov;
    assign o_quad_x    = r_x;
    assign o_quad_y    = r_y;
    assign o_quad_w    = r_w;
    assign o_quad_h    = r_h;
    assign o_quad_u0   = r_u0;
    assign o_quad_v0   = r_v0;
    assign o_quad_u1   = r_u1;
    assign o_quad_v1   = r_v1;
    assign o_tint_out  = r_tint;
    assign o_last_quad = r_last;

    // an idle walk may load the next item while the last word waits
    `NSQ_ASSERT_NEXT(a_last_flag, emit && $onehot(r_mask), o_last_quad, "last cell not flagged")
    `NSQ_ASSERT_NEXT(a_mask_hold, r_ov && i_out_stall && (r_mask != '0), $stable(r_mask), "cell walk advanced under stall")
    `NSQ_ASSERT(a_load_idle, (take && (i_geom.mask != '0)) |-> (r_mask == '0 || $onehot(r_mask)), "item loaded over busy emitter")

endmodule
